// ===== hdl/clte_pkg.sv =====
// Shared types and constants of the caching lock table engine.
// Used by the channel interfaces, the controller, the datapath and the top level.
package clte_pkg;

	localparam int OPCODE_W = 2;
	localparam int LOCK_W   = 64;
	localparam int CLIENT_W = 4;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;
	localparam int TOTAL_W  = 32;

	localparam logic [OPCODE_W-1:0] OP_ACQUIRE = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_STAT    = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_NOP     = 2'd3;

	localparam logic [KIND_W-1:0] KIND_REPLY  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REVOKE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RETRY  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RETRY   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

	typedef logic [1:0] out_sel_t;
	localparam out_sel_t SEL_MSG_A = 2'd0;
	localparam out_sel_t SEL_MSG_B = 2'd1;
	localparam out_sel_t SEL_REPLY = 2'd2;

	// commands from the controller to the datapath
	typedef struct packed {
		logic     capture;
		logic     scan;
		logic     exec;
		logic     load_out;
		out_sel_t out_sel;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic is_stat;
		logic is_nop;
		logic hit;
		logic miss;
		logic msg_a_valid;
		logic msg_b_valid;
		logic out_free;
	} sts_t;

endpackage

// ===== hdl/clte_ifs.sv =====
// Request and result channel interfaces of the caching lock table engine.
// Depends on clte_pkg for the field widths.
interface clte_req_if import clte_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [LOCK_W-1:0]   lock_id;
	logic [CLIENT_W-1:0] client_id;

	modport source (output valid, output opcode, output lock_id, output client_id, input ready);
	modport sink (input valid, input opcode, input lock_id, input client_id, output ready);
endinterface

interface clte_rsp_if import clte_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   item_kind;
	logic [CLIENT_W-1:0] target_client;
	logic [LOCK_W-1:0]   message_lock;
	logic [STATUS_W-1:0] reply_status;
	logic [TOTAL_W-1:0]  acquire_total;
	logic                last_item;

	modport source (output valid, output item_kind, output target_client, output message_lock,
		output reply_status, output acquire_total, output last_item, input ready);
	modport sink (input valid, input item_kind, input target_client, input message_lock,
		input reply_status, input acquire_total, input last_item, output ready);
endinterface

// ===== hdl/caching_lock_table_engine.sv =====
// Top level of the caching lock table engine: controller plus datapath.
// Depends on clte_pkg, clte_ifs, clte_ctrl and clte_dp.
//
// Lock server table: acquire, release and stat requests come in on req, and
// revoke, retry and reply items go out on rsp, the reply always last and
// flagged by last_item. One request is worked at a time. The lock id is looked
// up by scanning the used part of the table memory one entry per cycle through
// a registered read. An acquire or release passes decode, scan, exec and the
// emit states, with S_EMIT_B added when it sends two messages. A stat query
// skips the scan, and an ignored opcode goes back to idle after decode. The
// emit states wait while the output register is stalled. A new request is
// taken while the final reply still waits in the output register. Entries
// are allocated in order and never freed, so a fill count stands in for
// valid bits and no clearing pass follows reset.
module caching_lock_table_engine import clte_pkg::*; #(
	parameter int TABLE_ENTRIES = 16,
	parameter int CLIENTS = 16
) (
	input logic      clk,
	input logic      arst_n,
	clte_req_if.sink req,
	clte_rsp_if.source rsp
);

	cmd_t cmd;
	sts_t sts;

	clte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	clte_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.CLIENTS       (CLIENTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.opcode        (req.opcode),
		.lock_id       (req.lock_id),
		.client_id     (req.client_id),
		.rsp_valid     (rsp.valid),
		.rsp_ready     (rsp.ready),
		.item_kind     (rsp.item_kind),
		.target_client (rsp.target_client),
		.message_lock  (rsp.message_lock),
		.reply_status  (rsp.reply_status),
		.acquire_total (rsp.acquire_total),
		.last_item     (rsp.last_item)
	);

endmodule

// ===== hdl/clte_ctrl.sv =====
// Controller of the caching lock table engine: sequences decode, table scan,
// update and result emission. Depends on clte_pkg for the command and status types.
module clte_ctrl import clte_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_EXEC   = 3'd3;
	localparam logic [2:0] S_EMIT_A = 3'd4;
	localparam logic [2:0] S_EMIT_B = 3'd5;
	localparam logic [2:0] S_EMIT_R = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.out_sel = SEL_REPLY;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.is_nop) begin
					state_d = S_IDLE;
				end else if (sts.is_stat) begin
					state_d = S_EXEC;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit || sts.miss) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d = S_EMIT_A;
			end
			S_EMIT_A: begin
				if (!sts.msg_a_valid) begin
					state_d = S_EMIT_R;
				end else if (sts.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_sel = SEL_MSG_A;
					state_d = sts.msg_b_valid ? S_EMIT_B : S_EMIT_R;
				end
			end
			S_EMIT_B: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_sel = SEL_MSG_B;
					state_d = S_EMIT_R;
				end
			end
			S_EMIT_R: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_sel = SEL_REPLY;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/clte_dp.sv =====
// Datapath of the caching lock table engine: request registers, the lock table
// memory with its scan, the entry update, the counters and the output register.
// Depends on clte_pkg.
module clte_dp import clte_pkg::*; #(
	parameter int TABLE_ENTRIES = 16,
	parameter int CLIENTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic [OPCODE_W-1:0] opcode,
	input  logic [LOCK_W-1:0]   lock_id,
	input  logic [CLIENT_W-1:0] client_id,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic [KIND_W-1:0]   item_kind,
	output logic [CLIENT_W-1:0] target_client,
	output logic [LOCK_W-1:0]   message_lock,
	output logic [STATUS_W-1:0] reply_status,
	output logic [TOTAL_W-1:0]  acquire_total,
	output logic                last_item
);

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	// lock table
	logic [LOCK_W-1:0]   key_mem   [TABLE_ENTRIES];
	logic                held_mem  [TABLE_ENTRIES];
	logic [CLIENT_W-1:0] owner_mem [TABLE_ENTRIES];
	logic                rev_mem   [TABLE_ENTRIES];
	logic [CLIENTS-1:0]  wait_mem  [TABLE_ENTRIES];

	logic [OPCODE_W-1:0] op_q;
	logic [LOCK_W-1:0]   lock_q;
	logic [CLIENT_W-1:0] client_q;

	logic [CW-1:0]      fill_q;
	logic [TOTAL_W-1:0] count_q;
	logic [CW-1:0]      scan_q;
	logic               issue;

	logic                rd_vld_s1;
	logic [AW-1:0]       rd_idx_s1;
	logic [LOCK_W-1:0]   rd_key_s1;
	logic                rd_held_s1;
	logic [CLIENT_W-1:0] rd_owner_s1;
	logic                rd_rev_s1;
	logic [CLIENTS-1:0]  rd_wait_s1;

	logic                found_q;
	logic [AW-1:0]       ent_idx_q;
	logic                ent_held_q;
	logic [CLIENT_W-1:0] ent_owner_q;
	logic                ent_rev_q;
	logic [CLIENTS-1:0]  ent_wait_q;

	logic                a_valid_q;
	logic [KIND_W-1:0]   a_kind_q;
	logic [CLIENT_W-1:0] a_tgt_q;
	logic                b_valid_q;
	logic [STATUS_W-1:0] rs_q;
	logic [TOTAL_W-1:0]  total_q;

	logic                hit;
	logic                full;
	logic [CLIENTS-1:0]  wbit;
	logic [CLIENTS-1:0]  low_wait;
	logic [CLIENT_W-1:0] first;
	logic                multi;

	logic                wr_en;
	logic [AW-1:0]       wr_idx;
	logic                n_held;
	logic [CLIENT_W-1:0] n_owner;
	logic                n_rev;
	logic [CLIENTS-1:0]  n_wait;
	logic                alloc;
	logic                cnt_inc;
	logic                a_valid;
	logic [KIND_W-1:0]   a_kind;
	logic [CLIENT_W-1:0] a_tgt;
	logic                b_valid;
	logic [STATUS_W-1:0] rs;
	logic [TOTAL_W-1:0]  total;

	assign issue = cmd.scan && (scan_q < fill_q);
	assign hit   = rd_vld_s1 && (rd_key_s1 == lock_q);
	assign full  = (fill_q == CW'(TABLE_ENTRIES));

	assign sts.is_stat     = (op_q == OP_STAT);
	assign sts.is_nop      = (op_q == OP_NOP);
	assign sts.hit         = hit;
	assign sts.miss        = !rd_vld_s1 && (scan_q == fill_q);
	assign sts.msg_a_valid = a_valid_q;
	assign sts.msg_b_valid = b_valid_q;
	assign sts.out_free    = !rsp_valid || rsp_ready;

	// clients at or above CLIENTS shift out of the wait bit and are never recorded as waiters
	assign wbit     = {{(CLIENTS-1){1'b0}}, 1'b1} << client_q;
	assign low_wait = ent_wait_q & (~ent_wait_q + {{(CLIENTS-1){1'b0}}, 1'b1});
	assign multi    = (ent_wait_q & (ent_wait_q - {{(CLIENTS-1){1'b0}}, 1'b1})) != '0;

	always_comb begin
		first = '0;
		for (int i = 0; i < CLIENTS; i++) begin
			if (low_wait[i]) begin
				first = first | CLIENT_W'(i);
			end
		end
	end

	// entry update and result plan for the captured request
	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = ent_idx_q;
		n_held  = ent_held_q;
		n_owner = ent_owner_q;
		n_rev   = ent_rev_q;
		n_wait  = ent_wait_q;
		alloc   = 1'b0;
		cnt_inc = 1'b0;
		a_valid = 1'b0;
		a_kind  = KIND_REVOKE;
		a_tgt   = ent_owner_q;
		b_valid = 1'b0;
		rs      = ST_OK;
		total   = '0;
		case (op_q)
			OP_ACQUIRE: begin
				if (!found_q && full) begin
					rs = ST_FULL;
				end else begin
					cnt_inc = 1'b1;
					wr_en = 1'b1;
					if (!found_q) begin
						alloc = 1'b1;
						wr_idx = fill_q[AW-1:0];
					end
					if (!found_q || !ent_held_q) begin
						n_held = 1'b1;
						n_owner = client_q;
						n_rev = 1'b0;
						n_wait = found_q ? (ent_wait_q & ~wbit) : '0;
					end else begin
						n_wait = ent_wait_q | wbit;
						n_rev = 1'b1;
						rs = ST_RETRY;
						a_valid = !ent_rev_q;
					end
				end
			end
			OP_RELEASE: begin
				if (!found_q) begin
					rs = ST_UNKNOWN;
				end else begin
					wr_en = 1'b1;
					n_held = 1'b0;
					n_owner = '0;
					n_rev = 1'b0;
					if (ent_wait_q != '0) begin
						a_valid = 1'b1;
						a_kind = KIND_RETRY;
						a_tgt = first;
						b_valid = multi;
					end
				end
			end
			OP_STAT: begin
				total = count_q;
			end
			default: begin
			end
		endcase
	end

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			key_mem[wr_idx]   <= lock_q;
			held_mem[wr_idx]  <= n_held;
			owner_mem[wr_idx] <= n_owner;
			rev_mem[wr_idx]   <= n_rev;
			wait_mem[wr_idx]  <= n_wait;
		end
		if (issue) begin
			rd_key_s1   <= key_mem[scan_q[AW-1:0]];
			rd_held_s1  <= held_mem[scan_q[AW-1:0]];
			rd_owner_s1 <= owner_mem[scan_q[AW-1:0]];
			rd_rev_s1   <= rev_mem[scan_q[AW-1:0]];
			rd_wait_s1  <= wait_mem[scan_q[AW-1:0]];
			rd_idx_s1   <= scan_q[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			count_q   <= '0;
			scan_q    <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
			a_valid_q <= 1'b0;
			b_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				scan_q <= '0;
				rd_vld_s1 <= 1'b0;
				found_q <= 1'b0;
			end else if (cmd.scan) begin
				rd_vld_s1 <= issue;
				if (issue) begin
					scan_q <= scan_q + CW'(1);
				end
				if (hit) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.exec) begin
				a_valid_q <= a_valid;
				b_valid_q <= b_valid;
				if (alloc) begin
					fill_q <= fill_q + CW'(1);
				end
				if (cnt_inc) begin
					count_q <= count_q + TOTAL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= opcode;
			lock_q <= lock_id;
			client_q <= client_id;
		end
		// hold the matching entry once the scan finds it
		if (cmd.scan && hit) begin
			ent_idx_q   <= rd_idx_s1;
			ent_held_q  <= rd_held_s1;
			ent_owner_q <= rd_owner_s1;
			ent_rev_q   <= rd_rev_s1;
			ent_wait_q  <= rd_wait_s1;
		end
		if (cmd.exec) begin
			a_kind_q <= a_kind;
			a_tgt_q  <= a_tgt;
			rs_q     <= rs;
			total_q  <= total;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			message_lock <= lock_q;
			case (cmd.out_sel)
				SEL_MSG_A: begin
					item_kind     <= a_kind_q;
					target_client <= a_tgt_q;
					reply_status  <= ST_OK;
					acquire_total <= '0;
					last_item     <= 1'b0;
				end
				SEL_MSG_B: begin
					item_kind     <= KIND_REVOKE;
					target_client <= a_tgt_q;
					reply_status  <= ST_OK;
					acquire_total <= '0;
					last_item     <= 1'b0;
				end
				default: begin
					item_kind     <= KIND_REPLY;
					target_client <= client_q;
					reply_status  <= rs_q;
					acquire_total <= total_q;
					last_item     <= 1'b1;
				end
			endcase
		end
	end

endmodule
